/* sv/lrr_pkg.sv */
package lrr_pkg;

    localparam int SEED_W    = 31;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * SEED_W;
    localparam int DIV_STEPS = SEED_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int ADDR_W    = 5;

    // Register map, index = byte address / 4
    localparam logic [2:0] REG_MULTIPLIER = 3'd0;
    localparam logic [2:0] REG_MODULUS    = 3'd1;
    localparam logic [2:0] REG_SPLIT_QUOT = 3'd2;
    localparam logic [2:0] REG_SPLIT_REM  = 3'd3;
    localparam logic [2:0] REG_START_SEED = 3'd4;

    localparam logic [SEED_W-1:0] RST_MULTIPLIER = 31'd16807;
    localparam logic [SEED_W-1:0] RST_MODULUS    = 31'd2147483647;
    localparam logic [SEED_W-1:0] RST_SPLIT_QUOT = 31'd127773;
    localparam logic [SEED_W-1:0] RST_SPLIT_REM  = 31'd2836;
    localparam logic [SEED_W-1:0] RST_START_SEED = 31'd1;

    localparam logic OP_RAW    = 1'b0;
    localparam logic OP_RANGED = 1'b1;

    typedef struct packed {
        logic [SEED_W-1:0] multiplier;
        logic [SEED_W-1:0] modulus;
        logic [SEED_W-1:0] split_quot;
        logic [SEED_W-1:0] split_rem;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic div_load_split;
        logic div_load_mod;
        logic div_step;
        logic mul_plus;
        logic mul_minus;
        logic compare;
        logic fix;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic span_err;
    } t_dp_stat;

endpackage

/* sv/lehmer_rng_ranged.sv */
// Park-Miller style multiplicative generator, stepped by Schrage's split so
// that no product exceeds 62 bits. Each input beat advances the seed once:
// the seed is divided by q with a bit-serial restoring divider, a*lo and
// r*hi are formed in turn on one shared 31x31 multiplier, then compared and
// folded, adding m when a*lo <= r*hi. A raw request (tuser = 0) returns the
// new seed; a ranged request (tuser = 1) orders the two bounds, then takes
// the seed modulo the span on the same divider (a load step, then the divide
// steps) and adds the lower bound, wrapped to 32 bits.
// A range covering all 2^32 values returns zero with span_error set; the
// seed still advances. Items are worked one at a time: no new beat is
// accepted until the last result has been loaded into the output register.
// A new beat is taken while the last result still waits on the output.
// Writing the start_seed register also reloads the seed; write registers
// only while no item is in flight.
module lehmer_rng_ranged
    import lrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [63:0]       i_s_tdata,   // [31:0] range_from, [63:32] range_to
    input  logic              i_s_tuser,   // [0] op: 0 raw seed, 1 ranged
    // Output stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [31:0]       o_m_tdata,   // [31:0] value
    output logic              o_m_tuser,   // [0] span_error
    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0] pwdata,
    output logic [WORD_W-1:0] prdata,
    output logic              pready
);

    t_cfg              cfg;
    logic              seed_load;
    logic [SEED_W-1:0] seed_val;
    t_dp_cmd           cmd;
    t_dp_stat          stat;

    lrr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cfg       (cfg),
        .o_seed_load (seed_load),
        .o_seed_val  (seed_val)
    );

    // Sequence the divide, multiply and fold steps
    lrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Seed state, divider, multiplier and the output register
    lrr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_seed_load (seed_load),
        .i_seed_val  (seed_val),
        .i_cmd       (cmd),
        .i_in_op     (i_s_tuser),
        .i_in_from   (i_s_tdata[31:0]),
        .i_in_to     (i_s_tdata[63:32]),
        .o_stat      (stat),
        .o_out_value (o_m_tdata),
        .o_out_err   (o_m_tuser)
    );

endmodule

/* sv/lrr_regs.sv */
module lrr_regs
    import lrr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready,
    output t_cfg                  o_cfg,
    output logic                  o_seed_load,
    output logic [SEED_W-1:0]     o_seed_val
);

    logic [SEED_W-1:0] r_multiplier;
    logic [SEED_W-1:0] r_modulus;
    logic [SEED_W-1:0] r_split_quot;
    logic [SEED_W-1:0] r_split_rem;
    logic [SEED_W-1:0] r_start_seed;
    logic              wr_en;
    logic [2:0]        reg_idx;
    logic [SEED_W-1:0] wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_val  = pwdata[SEED_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multiplier <= RST_MULTIPLIER;
            r_modulus    <= RST_MODULUS;
            r_split_quot <= RST_SPLIT_QUOT;
            r_split_rem  <= RST_SPLIT_REM;
            r_start_seed <= RST_START_SEED;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MULTIPLIER: r_multiplier <= wr_val;
                REG_MODULUS:    r_modulus    <= wr_val;
                REG_SPLIT_QUOT: r_split_quot <= wr_val;
                REG_SPLIT_REM:  r_split_rem  <= wr_val;
                REG_START_SEED: r_start_seed <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MULTIPLIER: prdata = {1'b0, r_multiplier};
            REG_MODULUS:    prdata = {1'b0, r_modulus};
            REG_SPLIT_QUOT: prdata = {1'b0, r_split_quot};
            REG_SPLIT_REM:  prdata = {1'b0, r_split_rem};
            REG_START_SEED: prdata = {1'b0, r_start_seed};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.multiplier = r_multiplier;
    assign o_cfg.modulus    = r_modulus;
    assign o_cfg.split_quot = r_split_quot;
    assign o_cfg.split_rem  = r_split_rem;

    // A seed write also reloads the generator state
    assign o_seed_load = wr_en && (reg_idx == REG_START_SEED);
    assign o_seed_val  = wr_val;

endmodule

/* sv/lrr_dpath.sv */
module lrr_dpath
    import lrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_seed_load,
    input  logic [SEED_W-1:0] i_seed_val,
    input  t_dp_cmd           i_cmd,
    input  logic              i_in_op,
    input  logic [WORD_W-1:0] i_in_from,
    input  logic [WORD_W-1:0] i_in_to,
    output t_dp_stat          o_stat,
    output logic [WORD_W-1:0] o_out_value,
    output logic              o_out_err
);

    logic [SEED_W-1:0] r_seed;
    logic              r_op;
    logic              r_err;
    logic [WORD_W-1:0] r_lo_bound;
    logic [WORD_W-1:0] r_span;
    logic [WORD_W-1:0] r_divisor;
    logic [WORD_W-1:0] r_rem;
    logic [SEED_W-1:0] r_quo;
    logic [PROD_W-1:0] r_plus;
    logic [PROD_W-1:0] r_minus;
    logic              r_le;
    logic [SEED_W-1:0] r_diff;
    logic [WORD_W-1:0] r_out_value;
    logic              r_out_err;

    logic              swap;
    logic [WORD_W-1:0] lo_b;
    logic [WORD_W-1:0] hi_b;
    logic [WORD_W-1:0] gap;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W:0]   div_ext;
    logic [WORD_W:0]   rem_sub;
    logic              ge;
    logic [SEED_W-1:0] split_hi;
    logic [SEED_W-1:0] mul_a;
    logic [SEED_W-1:0] mul_b;
    logic [PROD_W-1:0] product;
    logic [SEED_W-1:0] n_seed;
    logic [WORD_W-1:0] n_out_value;

    // Order the bounds as signed values
    assign swap = $signed(i_in_from) > $signed(i_in_to);
    assign lo_b = swap ? i_in_to : i_in_from;
    assign hi_b = swap ? i_in_from : i_in_to;
    assign gap  = hi_b - lo_b;

    // Restoring divider, one quotient bit per step
    assign rem_sh  = {r_rem, r_quo[SEED_W-1]};
    assign div_ext = {1'b0, r_divisor};
    assign ge      = rem_sh >= div_ext;
    assign rem_sub = rem_sh - div_ext;

    // Zero quotient register means no split: hi is zero, lo is the seed
    assign split_hi = (i_cfg.split_quot == '0) ? '0 : r_quo;

    // One shared multiplier for a*lo and r*hi
    assign mul_a   = i_cmd.mul_plus ? i_cfg.multiplier : i_cfg.split_rem;
    assign mul_b   = i_cmd.mul_plus ? r_rem[SEED_W-1:0] : split_hi;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign n_seed = r_diff + (r_le ? i_cfg.modulus : '0);

    always_comb begin
        if (r_op == OP_RAW) begin
            n_out_value = {1'b0, r_seed};
        end else if (r_err) begin
            n_out_value = '0;
        end else begin
            n_out_value = r_rem + r_lo_bound;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= RST_START_SEED;
        end else if (i_seed_load) begin
            r_seed <= i_seed_val;
        end else if (i_cmd.fix) begin
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= i_in_op;
            r_err      <= (i_in_op == OP_RANGED) && (gap == '1);
            r_lo_bound <= lo_b;
            r_span     <= gap + 1'b1;
        end
        if (i_cmd.div_load_split) begin
            r_rem     <= '0;
            r_quo     <= r_seed;
            r_divisor <= {1'b0, i_cfg.split_quot};
        end else if (i_cmd.div_load_mod) begin
            r_rem     <= '0;
            r_quo     <= r_seed;
            r_divisor <= r_span;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            r_quo <= {r_quo[SEED_W-2:0], ge};
        end
        if (i_cmd.mul_plus) begin
            r_plus <= product;
        end
        if (i_cmd.mul_minus) begin
            r_minus <= product;
        end
        if (i_cmd.compare) begin
            r_le   <= r_plus <= r_minus;
            r_diff <= r_plus[SEED_W-1:0] - r_minus[SEED_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_value <= n_out_value;
            r_out_err   <= r_err;
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.span_err = r_err;
    assign o_out_value     = r_out_value;
    assign o_out_err       = r_out_err;

    // A seed write wins over the fold; a zero split quotient leaves no minus term
    a_seed_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seed_load |=> r_seed == $past(i_seed_val))
        else $error("seed load not taken");
    a_split_zero_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul_minus && i_cfg.split_quot == '0) |=> r_minus == '0)
        else $error("zero split quotient must give zero minus term");
    a_err_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_in && i_in_op == OP_RAW) |=> !r_err)
        else $error("raw request flagged as full span");

endmodule

/* sv/lrr_ctrl.sv */
module lrr_ctrl
    import lrr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_DIV_SPLIT = 9'b000000010,
        ST_MUL_PLUS  = 9'b000000100,
        ST_MUL_MINUS = 9'b000001000,
        ST_COMPARE   = 9'b000010000,
        ST_FIX       = 9'b000100000,
        ST_MOD_START = 9'b001000000,
        ST_DIV_MOD   = 9'b010000000,
        ST_FINISH    = 9'b100000000
    } t_state;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_room;
    logic             accept;

    assign out_room   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_in        = 1'b1;
                    o_cmd.div_load_split = 1'b1;
                    n_cnt                = '0;
                    n_state              = ST_DIV_SPLIT;
                end
            end
            ST_DIV_SPLIT: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_MUL_PLUS;
                end
            end
            ST_MUL_PLUS: begin
                o_cmd.mul_plus = 1'b1;
                n_state        = ST_MUL_MINUS;
            end
            ST_MUL_MINUS: begin
                o_cmd.mul_minus = 1'b1;
                n_state         = ST_COMPARE;
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = ST_FIX;
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                if (i_stat.op == OP_RANGED && !i_stat.span_err) begin
                    n_state = ST_MOD_START;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_MOD_START: begin
                o_cmd.div_load_mod = 1'b1;
                n_cnt              = '0;
                n_state            = ST_DIV_MOD;
            end
            ST_DIV_MOD: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_room) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_out_valid && !i_m_tready) |=> r_state == ST_FINISH)
        else $error("result dropped while output stalled");
    a_split_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_SPLIT && r_cnt == LAST_STEP) |=> r_state == ST_MUL_PLUS)
        else $error("split divider ran the wrong number of steps");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_SPLIT || r_state == ST_DIV_MOD) |-> r_cnt <= LAST_STEP)
        else $error("divider step count out of range");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_m_tvalid && r_state == ST_IDLE))
        else $error("output load did not raise valid");

endmodule

/* test/lehmer_rng_ranged_test.sv */
module lehmer_rng_ranged_test
    import lrr_pkg::*;
();

    // Longest quiet stretch of a correct run: a sender gap, a ranged draw
    // and a receiver stall.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Drain time after the last result: one ranged draw and some margin.
    localparam int TAIL_CYCLES     = 80;
    localparam int NUM_DIRECTED    = 20;
    localparam int NUM_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 157;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [30:0] SEED_MAX = 31'h7FFF_FFFE;
    localparam logic [30:0] MOD_MAX  = 31'h7FFF_FFFF;

    // One directed beat; value and err are used only when pinned is set.
    typedef struct packed {
        logic        op;
        logic [31:0] bound_a;
        logic [31:0] bound_b;
        logic        pinned;
        logic [31:0] value;
        logic        err;
    } t_draw_row;

    typedef struct packed {
        logic [31:0] value;
        logic        span_err;
    } t_draw_result;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    wire               o_s_tready;
    logic [63:0]       i_s_tdata  = '0;   // [31:0] range_from, [63:32] range_to
    logic              i_s_tuser  = 1'b0; // [0] op
    wire               o_m_tvalid;
    logic              i_m_tready = 1'b0;
    wire  [31:0]       o_m_tdata;         // [31:0] value
    wire               o_m_tuser;         // [0] span_error
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [WORD_W-1:0] pwdata     = '0;
    wire  [WORD_W-1:0] prdata;
    wire               pready;

    // Directed beats may carry a hand-written expectation alongside the data.
    logic              beat_pinned  = 1'b0;
    logic [31:0]       pinned_value = '0;
    logic              pinned_err   = 1'b0;

    // Shadow of the generator: configuration and current seed.
    logic [30:0]       gen_mult = RST_MULTIPLIER;
    logic [30:0]       gen_mod  = RST_MODULUS;
    logic [30:0]       gen_quot = RST_SPLIT_QUOT;
    logic [30:0]       gen_rem  = RST_SPLIT_REM;
    logic [30:0]       gen_seed = RST_START_SEED;

    t_draw_result      draws_due[$];
    t_draw_row         directed_rows [0:NUM_DIRECTED-1];

    bit                idle_on        = 1'b1;
    int                sink_stall     = 0;
    int                idle_run       = 0;
    int                items_sent     = 0;
    int                beats_in       = 0;
    int                beats_out      = 0;
    int                ranged_count   = 0;
    int                full_span      = 0;
    int                settings_count = 1;
    int                fault_count    = 0;

    lehmer_rng_ranged dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Advance the seed one Schrage step: split by q, form a*lo - r*hi at
    // 64 bits, fold in m when the difference is not positive, keep 31 bits.
    function automatic logic [30:0] step_seed();
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        logic [63:0] plus_t;
        logic [63:0] minus_t;
        logic [63:0] fold;
        if (gen_quot == '0) begin
            // zero quotient: the whole seed goes to the low part
            hi_part = '0;
            lo_part = {33'd0, gen_seed};
        end else begin
            hi_part = {33'd0, gen_seed / gen_quot};
            lo_part = {33'd0, gen_seed % gen_quot};
        end
        plus_t  = {33'd0, gen_mult} * lo_part;
        minus_t = {33'd0, gen_rem} * hi_part;
        fold    = plus_t - minus_t;
        if (plus_t <= minus_t) begin
            fold = fold + {33'd0, gen_mod};
        end
        gen_seed = fold[30:0];
        return gen_seed;
    endfunction

    // Expected result of one draw; always advances the shadow seed.
    function automatic t_draw_result predict_draw(input logic op, input logic [31:0] b0,
                                                  input logic [31:0] b1);
        t_draw_result res;
        logic [30:0]  s;
        logic [31:0]  lower;
        logic [31:0]  upper;
        logic [32:0]  span;
        s = step_seed();
        res.value    = {1'b0, s};
        res.span_err = 1'b0;
        if (op == OP_RANGED) begin
            // order the bounds as signed values
            if ($signed(b0) > $signed(b1)) begin
                lower = b1;
                upper = b0;
            end else begin
                lower = b0;
                upper = b1;
            end
            span = {1'b0, upper - lower} + 33'd1;
            if (span[32]) begin
                // full span would divide by 2^32: flag it, value zero
                res.value    = '0;
                res.span_err = 1'b1;
            end else begin
                res.value = ({1'b0, s} % span[31:0]) + lower;
            end
        end
        return res;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Scoreboard: track register writes, predict each input beat, check
    // each output beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_draw_result due;
        bit           moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            gen_mult = RST_MULTIPLIER;
            gen_mod  = RST_MODULUS;
            gen_quot = RST_SPLIT_QUOT;
            gen_rem  = RST_SPLIT_REM;
            gen_seed = RST_START_SEED;
        end else begin
            if (psel && penable && pwrite && pready) begin
                moved = 1'b1;
                case (paddr[4:2])
                    REG_MULTIPLIER: gen_mult = pwdata[30:0];
                    REG_MODULUS:    gen_mod  = pwdata[30:0];
                    REG_SPLIT_QUOT: gen_quot = pwdata[30:0];
                    REG_SPLIT_REM:  gen_rem  = pwdata[30:0];
                    REG_START_SEED: gen_seed = pwdata[30:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                moved = 1'b1;
                due = predict_draw(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]);
                if (beat_pinned) begin
                    due.value    = pinned_value;
                    due.span_err = pinned_err;
                end
                if (i_s_tuser == OP_RANGED) ranged_count++;
                if (due.span_err) full_span++;
                draws_due.push_back(due);
                beats_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                beats_out++;
                if (draws_due.size() == 0) begin
                    note_fault($sformatf("Unexpected result beat: value %h span_error %b",
                                         o_m_tdata, o_m_tuser));
                end else begin
                    due = draws_due.pop_front();
                    if (o_m_tdata !== due.value) begin
                        note_fault($sformatf("Result %0d value: expected %h, got %h",
                                             beats_out, due.value, o_m_tdata));
                    end
                    if (o_m_tuser !== due.span_err) begin
                        note_fault($sformatf("Result %0d span_error: expected %b, got %b",
                                             beats_out, due.span_err, o_m_tuser));
                    end
                end
            end
        end
        if (moved) idle_run = 0;
        else idle_run++;
    end

    // Receiver: drop tready in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_stall = int'($urandom_range(1, 18));
        end
        i_m_tready <= (sink_stall == 0);
    end

    // Watchdog: end the run when nothing has moved for too long.
    initial begin
        @(posedge i_rst_n);
        while (idle_run < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_run, items_sent - beats_out);
        $display("Regression FAIL");
        $finish;
    end

    // Present one input beat and hold it until taken, then maybe idle.
    task automatic send_draw(input logic op, input logic [31:0] b0, input logic [31:0] b1,
                             input logic pinned, input logic [31:0] val, input logic err);
        i_s_tvalid   <= 1'b1;
        i_s_tuser    <= op;
        i_s_tdata    <= {b1, b0};
        beat_pinned  <= pinned;
        pinned_value <= val;
        pinned_err   <= err;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (beats_out != items_sent) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; psel stays high between
    // back-to-back writes and the caller drops it.
    task automatic reg_write(input logic [2:0] idx, input logic [30:0] val);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= {1'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
    endtask

    // Reprogram the generator once the block is idle; the seed write goes
    // last so it reloads the seed under the new settings.
    task automatic load_generator(input logic [30:0] a, input logic [30:0] m,
                                  input logic [30:0] q, input logic [30:0] r,
                                  input logic [30:0] s);
        wait_drained();
        reg_write(REG_MULTIPLIER, a);
        reg_write(REG_MODULUS, m);
        reg_write(REG_SPLIT_QUOT, q);
        reg_write(REG_SPLIT_REM, r);
        reg_write(REG_START_SEED, s);
        psel   <= 1'b0;
        pwrite <= 1'b0;
        settings_count++;
    endtask

    initial begin
        logic [30:0] a;
        logic [30:0] m;
        logic [30:0] q;
        logic [30:0] r;
        logic [30:0] s;
        logic [31:0] b0;
        logic [31:0] b1;
        logic        op;

        // Directed beats under reset settings. The first values of the
        // minimal standard sequence are well known; so are the full-span
        // error and single-value ranges.
        directed_rows[0]  = '{OP_RAW,    32'd0,   32'd0,   1'b1, 32'd16807,      1'b0};
        directed_rows[1]  = '{OP_RAW,    32'd0,   32'd0,   1'b1, 32'd282475249,  1'b0};
        directed_rows[2]  = '{OP_RANGED, INT_MIN, INT_MAX, 1'b1, 32'd0,          1'b1};
        directed_rows[3]  = '{OP_RAW,    INT_MIN, INT_MAX, 1'b1, 32'd984943658,  1'b0};
        directed_rows[4]  = '{OP_RANGED, INT_MAX, INT_MIN, 1'b1, 32'd0,          1'b1};
        directed_rows[5]  = '{OP_RANGED, 32'd5,   32'd5,   1'b1, 32'd5,          1'b0};
        directed_rows[6]  = '{OP_RANGED, 32'd0,   32'd0,   1'b1, 32'd0,          1'b0};
        directed_rows[7]  = '{OP_RANGED, INT_MIN, INT_MIN, 1'b1, INT_MIN,        1'b0};
        directed_rows[8]  = '{OP_RANGED, INT_MAX, INT_MAX, 1'b1, INT_MAX,        1'b0};
        directed_rows[9]  = '{OP_RAW,    '1,      '1,      1'b0, 32'd0,          1'b0};
        directed_rows[10] = '{OP_RANGED, 32'd0,   32'd1,   1'b0, 32'd0,          1'b0};
        directed_rows[11] = '{OP_RANGED, 32'd1,   32'd0,   1'b0, 32'd0,          1'b0};
        directed_rows[12] = '{OP_RANGED, '1,      32'd1,   1'b0, 32'd0,          1'b0};
        directed_rows[13] = '{OP_RANGED, 32'd0,   INT_MAX, 1'b0, 32'd0,          1'b0};
        directed_rows[14] = '{OP_RANGED, INT_MIN, 32'd0,   1'b0, 32'd0,          1'b0};
        directed_rows[15] = '{OP_RANGED, INT_MIN, INT_MAX - 32'd1, 1'b0, 32'd0,  1'b0};
        directed_rows[16] = '{OP_RANGED, INT_MIN + 32'd1, INT_MAX, 1'b0, 32'd0,  1'b0};
        directed_rows[17] = '{OP_RANGED, 32'd100, -32'sd100, 1'b0, 32'd0,        1'b0};
        directed_rows[18] = '{OP_RANGED, 32'd0,   -32'sd2,   1'b0, 32'd0,        1'b0};
        directed_rows[19] = '{OP_RAW, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'd0, 1'b0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_draw(directed_rows[i].op, directed_rows[i].bound_a, directed_rows[i].bound_b,
                      directed_rows[i].pinned, directed_rows[i].value, directed_rows[i].err);
        end

        for (int p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                // widest values: q above seed so a*seed overflows the 31 bits
                1: load_generator(SEED_MAX, MOD_MAX, MOD_MAX, SEED_MAX, SEED_MAX);
                // narrowest values: m = 2, r = 0
                2: load_generator(31'd1, 31'd2, 31'd1, 31'd0, 31'd1);
                // q = 1 with the largest r: r*hi swamps a*lo
                3: load_generator(31'd1, MOD_MAX, 31'd1, SEED_MAX, SEED_MAX);
                // zero quotient: the split leaves the seed whole
                4: load_generator(31'd48271, MOD_MAX, 31'd0, 31'd3399, 31'd12345);
                // the alternate minimal standard multiplier
                5: load_generator(31'd48271, MOD_MAX, 31'd44488, 31'd3399,
                                  31'($urandom_range(1, SEED_MAX)));
                default: begin
                    a = $urandom_range(0, 1) ? 31'($urandom_range(1, 65535))
                                             : 31'($urandom_range(1, SEED_MAX));
                    m = 31'($urandom_range(2, MOD_MAX));
                    if ($urandom_range(0, 1)) begin
                        // consistent Schrage split of m by a
                        q = m / a;
                        r = m % a;
                        if (q == '0) q = 31'd1;
                    end else begin
                        q = $urandom_range(0, 2) == 0 ? 31'($urandom_range(1, 255))
                                                      : 31'($urandom_range(1, MOD_MAX));
                        r = 31'($urandom_range(0, SEED_MAX));
                    end
                    s = 31'($urandom_range(1, SEED_MAX));
                    load_generator(a, m, q, r, s);
                end
            endcase

            // Idling on about three phases in four, at random, and none on the last.
            idle_on = (p == NUM_PHASES) ? 1'b0 : ($urandom_range(0, 3) != 0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                op = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        b0 = $urandom();
                        b1 = $urandom();
                    end
                    4, 5: begin
                        // narrow range, either order
                        b0 = $urandom();
                        b1 = b0 + $urandom_range(0, 255);
                        if ($urandom_range(0, 1)) begin
                            b0 = b1;
                            b1 = b1 - $urandom_range(0, 255);
                        end
                    end
                    6: begin
                        b0 = $urandom_range(0, 1) ? INT_MIN : INT_MAX;
                        b1 = b0 ^ '1;
                    end
                    7: begin
                        b0 = $urandom();
                        b1 = b0;
                    end
                    8: begin
                        case ($urandom_range(0, 4))
                            0: b0 = INT_MIN;
                            1: b0 = INT_MAX;
                            2: b0 = '0;
                            3: b0 = '1;
                            default: b0 = 32'd1;
                        endcase
                        case ($urandom_range(0, 4))
                            0: b1 = INT_MIN;
                            1: b1 = INT_MAX;
                            2: b1 = '0;
                            3: b1 = '1;
                            default: b1 = 32'd1;
                        endcase
                    end
                    default: begin
                        // at or just short of the full span
                        b0 = INT_MIN + $urandom_range(0, 3);
                        b1 = INT_MAX - $urandom_range(0, 3);
                    end
                endcase
                send_draw(op, b0, b1, 1'b0, 32'd0, 1'b0);
                // now and then let the pipeline run dry before the next beat
                if ($urandom_range(0, 199) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (draws_due.size() != 0) begin
            note_fault($sformatf("%0d predicted results never arrived", draws_due.size()));
        end

        $display("Drove %0d input beats (%0d ranged, %0d full span), checked %0d results",
                 beats_in, ranged_count, full_span, beats_out);
        $display("over %0d generator settings; %0d mismatches", settings_count, fault_count);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/lrr_pkg.sv
sv/lrr_regs.sv
sv/lrr_dpath.sv
sv/lrr_ctrl.sv
sv/lehmer_rng_ranged.sv
test/lehmer_rng_ranged_test.sv
